// File: rtl/core/sdpg_pkg.sv
// Shared types and constants for the step/direction pulse generator.
// No dependencies; every other file of the block refers to this package by scoped names.
package sdpg_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TARGET_W   = 32;
  localparam int unsigned STEP_POS_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_TARGET = 2'd1,
    CMD_ENABLE     = 2'd2,
    CMD_DISABLE    = 2'd3
  } cmd_e;

  localparam logic [MODE_W-1:0] MODE_POSITION = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TORQUE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_INTERVAL   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONFIGURED = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_DIR = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_LOW = 2'd3;

  typedef struct packed {
    cmd_e                        command;
    logic [MODE_W-1:0]           mode_sel;
    logic signed [TARGET_W-1:0]  target_amount;
  } item_t;

  typedef struct packed {
    logic                         step_issued;
    logic                         direction_level;
    logic                         enable_level;
    logic signed [STEP_POS_W-1:0] step_position;
  } result_t;

endpackage

// File: rtl/core/sdpg_motion.sv
// Channel state, configuration registers and the next-state logic for one request.
// Depends on sdpg_pkg for the request and result structs and the command codes.
module sdpg_motion #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned INTERVAL_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdpg_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [INTERVAL_WIDTH-1:0]      cfg_data_i,
  input  logic                           apply_i,
  input  sdpg_pkg::item_t                item_i,
  output sdpg_pkg::result_t              result_o
);

  localparam int unsigned CMP_W = (POSITION_WIDTH > sdpg_pkg::TARGET_W) ?
                                  POSITION_WIDTH : sdpg_pkg::TARGET_W;

  logic [INTERVAL_WIDTH-1:0] interval_q;
  logic                      configured_q;
  logic                      invert_q;
  logic                      enable_low_q;

  logic signed [POSITION_WIDTH-1:0]        pos_q, pos_d;
  logic [INTERVAL_WIDTH-1:0]               ticks_q, ticks_d;
  logic [sdpg_pkg::MODE_W-1:0]             mode_q, mode_d;
  logic signed [sdpg_pkg::TARGET_W-1:0]    target_q, target_d;
  logic                                    enabled_q, enabled_d;
  logic                                    direction_q, direction_d;

  logic [INTERVAL_WIDTH-1:0] tick_sat;
  logic signed [CMP_W-1:0]   pos_ext;
  logic signed [CMP_W-1:0]   tgt_ext;
  logic signed [CMP_W-1:0]   pos_out_ext;
  logic                      step;
  logic                      dir_pos;

  assign tick_sat = (ticks_q == '1) ? ticks_q : ticks_q + INTERVAL_WIDTH'(1);
  assign pos_ext  = CMP_W'(pos_q);
  assign tgt_ext  = CMP_W'(target_q);

  always_comb begin
    pos_d       = pos_q;
    ticks_d     = ticks_q;
    mode_d      = mode_q;
    target_d    = target_q;
    enabled_d   = enabled_q;
    direction_d = direction_q;
    step        = 1'b0;
    dir_pos     = 1'b0;
    case (item_i.command)
      sdpg_pkg::CMD_TICK: begin
        ticks_d = tick_sat;
        if (enabled_q && (interval_q != '0) && (tick_sat >= interval_q)) begin
          case (mode_q)
            sdpg_pkg::MODE_POSITION: begin
              step    = (pos_ext != tgt_ext);
              dir_pos = (tgt_ext > pos_ext);
            end
            sdpg_pkg::MODE_VELOCITY: begin
              step    = (target_q != '0);
              dir_pos = ~target_q[sdpg_pkg::TARGET_W-1];
            end
            sdpg_pkg::MODE_TORQUE, sdpg_pkg::MODE_IDLE: begin
              step = 1'b0;
            end
            default: begin
              step = 1'b0;
            end
          endcase
        end
        if (step) begin
          direction_d = dir_pos ^ invert_q;
          pos_d       = dir_pos ? pos_q + $signed(POSITION_WIDTH'(1))
                                : pos_q - $signed(POSITION_WIDTH'(1));
          ticks_d     = '0;
        end
      end
      sdpg_pkg::CMD_SET_TARGET: begin
        mode_d   = item_i.mode_sel;
        target_d = item_i.target_amount;
      end
      sdpg_pkg::CMD_ENABLE: begin
        if (configured_q) begin
          enabled_d = 1'b1;
        end
      end
      sdpg_pkg::CMD_DISABLE: begin
        enabled_d = 1'b0;
      end
      default: begin
        enabled_d = enabled_q;
      end
    endcase
  end

  // Position is shown sign-extended or truncated to the fixed result width.
  assign pos_out_ext = CMP_W'(pos_d);

  assign result_o.step_issued     = step;
  assign result_o.direction_level = direction_d;
  assign result_o.enable_level    = enabled_d ^ enable_low_q;
  assign result_o.step_position   = pos_out_ext[sdpg_pkg::STEP_POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= '0;
      configured_q <= 1'b0;
      invert_q     <= 1'b0;
      enable_low_q <= 1'b0;
      pos_q        <= '0;
      ticks_q      <= '1;
      mode_q       <= sdpg_pkg::MODE_POSITION;
      target_q     <= '0;
      enabled_q    <= 1'b0;
      direction_q  <= 1'b0;
    end else begin
      if (apply_i) begin
        pos_q       <= pos_d;
        ticks_q     <= ticks_d;
        mode_q      <= mode_d;
        target_q    <= target_d;
        enabled_q   <= enabled_d;
        direction_q <= direction_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          sdpg_pkg::REG_INTERVAL: begin
            interval_q <= cfg_data_i;
          end
          sdpg_pkg::REG_CONFIGURED: begin
            // Reconfiguring the channel always leaves it disabled.
            configured_q <= cfg_data_i[0];
            enabled_q    <= 1'b0;
            direction_q  <= 1'b0;
          end
          sdpg_pkg::REG_INVERT_DIR: begin
            invert_q <= cfg_data_i[0];
          end
          sdpg_pkg::REG_ENABLE_LOW: begin
            enable_low_q <= cfg_data_i[0];
          end
          default: begin
            interval_q <= interval_q;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/step_dir_pulse_generator_core.sv
// Top level of the step/direction pulse generator: request register, motion logic, result
// register and the valid/ready handshakes. Depends on sdpg_pkg and sdpg_motion.

// One request (tick, set target, enable or disable) enters per clock cycle. It is held
// in the request register, where the channel state is updated by a single pass of
// compare-and-count logic, and its result is then captured into and presented from the
// result register. The rate is one request per cycle as long as results are taken; a
// stalled result holds the result register and, one request later, the request register.
// Configuration writes are taken in any cycle with cfg_ready_o always high and must only
// be issued while no request is in flight.
module step_dir_pulse_generator_core #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned INTERVAL_WIDTH = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sdpg_pkg::REG_IDX_W-1:0]        cfg_index_i,
  input  logic [INTERVAL_WIDTH-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sdpg_pkg::CMD_W-1:0]            command_i,
  input  logic [sdpg_pkg::MODE_W-1:0]           mode_sel_i,
  input  logic signed [sdpg_pkg::TARGET_W-1:0]  target_amount_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  step_issued_o,
  output logic                                  direction_level_o,
  output logic                                  enable_level_o,
  output logic signed [sdpg_pkg::STEP_POS_W-1:0] step_position_o
);

  logic              s1_valid_q;
  sdpg_pkg::item_t   s1_item_q;
  logic              out_valid_q;
  sdpg_pkg::result_t out_res_q;
  sdpg_pkg::result_t res;
  logic              adv;
  logic              apply;

  assign adv         = ~out_valid_q | out_ready_i;
  assign in_ready_o  = ~s1_valid_q | adv;
  assign apply       = s1_valid_q & adv;
  assign cfg_ready_o = 1'b1;

  sdpg_motion #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_motion (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .apply_i     (apply),
    .item_i      (s1_item_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q.command       <= sdpg_pkg::cmd_e'(command_i);
      s1_item_q.mode_sel      <= mode_sel_i;
      s1_item_q.target_amount <= target_amount_i;
    end
    if (apply) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_issued_o     = out_res_q.step_issued;
  assign direction_level_o = out_res_q.direction_level;
  assign enable_level_o    = out_res_q.enable_level;
  assign step_position_o   = out_res_q.step_position;

  // Only a tick request can produce a step.
  a_step_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && (s1_item_q.command != sdpg_pkg::CMD_TICK)) |-> !res.step_issued)
    else $error("step issued on a request that is not a tick");

  // Back-pressure on the input only comes from an occupied request register behind a stalled result.
  a_ready_needs_full_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked request");

  // A new result appears only when a request was held in the request register.
  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q))
    else $error("result appeared without a request");

endmodule
